>>> rtl/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SVE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check on every clock edge, reset included.
`define SVE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("reset assertion failed");

`endif

>>> rtl/sve_pkg.sv
`timescale 1ns / 1ps

package sve_pkg;

  localparam int COAL_W         = 6;
  localparam int WORTH_W        = 16;
  localparam int DIFF_W         = WORTH_W + 1;
  localparam int CFG_W          = 3;
  localparam int AGENT_W        = 3;
  localparam int MT_W           = 27;
  localparam int Q_W            = 33;
  localparam int FRAC_W         = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int DEF_MAX_AGENTS = 6;
  localparam int FACT_SEL_W     = 4;
  localparam longint WORTH_SPAN = 65535;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;

  typedef struct packed {
    logic [COAL_W-1:0]         coalition;
    logic signed [WORTH_W-1:0] worth;
    logic                      last;
  } req_t;

  function automatic logic [15:0] fact_sel(input logic [FACT_SEL_W-1:0] k);
    logic [15:0] f;
    case (k)
      4'd0:    f = 16'd1;
      4'd1:    f = 16'd1;
      4'd2:    f = 16'd2;
      4'd3:    f = 16'd6;
      4'd4:    f = 16'd24;
      4'd5:    f = 16'd120;
      4'd6:    f = 16'd720;
      4'd7:    f = 16'd5040;
      default: f = 16'd40320;
    endcase
    return f;
  endfunction

  function automatic int acc_width(input int max_agents);
    return $clog2(longint'(fact_sel(FACT_SEL_W'(max_agents))) * WORTH_SPAN + 1) + 1;
  endfunction

  function automatic int fact_width(input int k);
    return $clog2(int'(fact_sel(FACT_SEL_W'(k))) + 1);
  endfunction

endpackage

>>> rtl/sve_in_if.sv
`timescale 1ns / 1ps

interface sve_in_if import sve_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [COAL_W-1:0]         coalition;
  logic signed [WORTH_W-1:0] worth;
  logic                      load_done;

  modport source (output valid, coalition, worth, load_done, input ready);
  modport sink   (input valid, coalition, worth, load_done, output ready);
  modport mon    (input valid, ready, coalition, worth, load_done);
endinterface

>>> rtl/sve_out_if.sv
`timescale 1ns / 1ps

interface sve_out_if import sve_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [AGENT_W-1:0]      agent;
  logic signed [MT_W-1:0]  marginal_total;
  logic signed [Q_W-1:0]   shapley_q16;
  logic                    final_agent;

  modport source (output valid, agent, marginal_total, shapley_q16, final_agent,
                  input ready);
  modport sink   (input valid, agent, marginal_total, shapley_q16, final_agent,
                  output ready);
  modport mon    (input valid, ready, agent, marginal_total, shapley_q16, final_agent);
endinterface

>>> rtl/shapley_value_engine.sv
// channel  dir  handshake    payload
// in_ch    in   valid/ready  coalition, worth, load_done
// out_ch   out  valid/ready  agent, marginal_total, shapley_q16, final_agent
// cfg      in   cfg_we       cfg_wdata -> agent_count
//
// Each request loads one table entry; a four-entry queue sits in front.
// A request with load_done starts a run: per agent, every subset passes the subset
// pipeline, which then drains, the bit-serial divider forms an ACC_W+16 = 43-bit
// quotient, and the result is emitted.
// Synchronous active-low reset clears the table valid bits, queue and counters;
// entries never written read as zero, so no clearing pass is needed.
// A stalled result holds the run; the queue takes requests until it fills.
`timescale 1ns / 1ps

module shapley_value_engine import sve_pkg::*; #(
  parameter int MAX_AGENTS = DEF_MAX_AGENTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  sve_in_if.sink           in_ch,
  sve_out_if.source        out_ch
);

  logic deq_valid;
  logic deq_ready;
  req_t deq_data;

  sve_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .deq_valid (deq_valid),
    .deq_data  (deq_data),
    .deq_ready (deq_ready)
  );

  sve_back #(
    .MAX_AGENTS (MAX_AGENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .deq_valid (deq_valid),
    .deq_data  (deq_data),
    .deq_ready (deq_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/sve_front.sv
`timescale 1ns / 1ps

module sve_front import sve_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sve_in_if.sink in_ch,
  output logic  deq_valid,
  output req_t  deq_data,
  input  logic  deq_ready
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  req_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;
  req_t             req;

  assign in_ch.ready = (count_r != CNT_W'(FIFO_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign deq_valid   = (count_r != '0);
  assign pop         = deq_valid && deq_ready;
  assign deq_data    = fifo_r[rd_ptr_r];

  always_comb begin
    req.coalition = in_ch.coalition;
    req.worth     = in_ch.worth;
    req.last      = in_ch.load_done;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/sve_div.sv
`timescale 1ns / 1ps

module sve_div import sve_pkg::*; #(
  parameter int ACC_W = 27,
  parameter int FW    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ACC_W-1:0]       dividend,
  input  logic [FW-1:0]                 divisor,
  output logic                          done,
  output logic signed [ACC_W+FRAC_W-1:0] quotient
);

  localparam int QW    = ACC_W + FRAC_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [FW-1:0]    rem_r;
  logic [FW-1:0]    div_r;
  logic [QW-1:0]    q_r;
  logic             neg_r;
  logic [ACC_W-1:0] mag;
  logic [FW:0]      rem_sh;
  logic [FW:0]      rem_sub;
  logic             take;

  assign mag     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign rem_sh  = {rem_r, q_r[QW-1]};
  assign take    = (rem_sh >= {1'b0, div_r});
  assign rem_sub = rem_sh - {1'b0, div_r};

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= {mag, {FRAC_W{1'b0}}};
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[ACC_W-1];
    end else if (busy_r) begin
      q_r   <= {q_r[QW-2:0], take};
      rem_r <= take ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/sve_back.sv
`timescale 1ns / 1ps

module sve_back import sve_pkg::*; #(
  parameter int MAX_AGENTS = DEF_MAX_AGENTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             deq_valid,
  input  req_t             deq_data,
  output logic             deq_ready,
  sve_out_if.source        out_ch
);

  localparam int DEPTH = 1 << MAX_AGENTS;
  localparam int IDX_W = MAX_AGENTS;
  localparam int JW    = MAX_AGENTS - 1;
  localparam int NW    = $clog2(MAX_AGENTS + 1);
  localparam int ACC_W = acc_width(MAX_AGENTS);
  localparam int FW    = fact_width(MAX_AGENTS);
  localparam int WW    = fact_width(MAX_AGENTS - 1);
  localparam int PW    = WW + 1 + DIFF_W;
  localparam int QW    = ACC_W + FRAC_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  localparam logic [JW-1:0]    ONES_J = '1;
  localparam logic [IDX_W-1:0] ONES_I = '1;

  logic [1:0]                state_r;
  logic [CFG_W-1:0]          agent_count_r;
  logic [NW-1:0]             n_eff;
  logic [NW-1:0]             a_r;
  logic [JW-1:0]             j_r;
  logic [JW-1:0]             j_last;
  logic [IDX_W-1:0]          low_mask;
  logic [IDX_W-1:0]          agent_bit;
  logic [IDX_W-1:0]          j_ext;
  logic [IDX_W-1:0]          addr_lo;
  logic [IDX_W-1:0]          addr_hi;
  logic [NW-1:0]             pc;

  logic signed [WORTH_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vbit_r;
  logic signed [WORTH_W-1:0] rd_hi_r;
  logic signed [WORTH_W-1:0] rd_lo_r;
  logic                      vh_r;
  logic                      vl_r;
  logic signed [WORTH_W-1:0] eff_hi;
  logic signed [WORTH_W-1:0] eff_lo;

  logic                      v1_r;
  logic                      v2_r;
  logic                      v3_r;
  logic [NW-1:0]             pc1_r;
  logic signed [DIFF_W-1:0]  diff2_r;
  logic [WW-1:0]             wt2_r;
  logic signed [PW-1:0]      prod3_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [NW-1:0]             pc_rest;
  logic [31:0]               wt_full;

  logic                      pop;
  logic [IDX_W-1:0]          wr_idx;
  logic                      pipe_empty;
  logic                      div_start;
  logic                      div_done;
  logic signed [QW-1:0]      div_q;
  logic                      out_free;
  logic                      emit;
  logic                      last_agent;

  always_comb begin
    if (int'(agent_count_r) < 2) begin
      n_eff = NW'(2);
    end else if (int'(agent_count_r) > MAX_AGENTS) begin
      n_eff = NW'(MAX_AGENTS);
    end else begin
      n_eff = NW'(agent_count_r);
    end
  end

  assign j_last    = ONES_J >> (NW'(MAX_AGENTS) - n_eff);
  assign low_mask  = ~(ONES_I << a_r);
  assign agent_bit = IDX_W'(1) << a_r;
  assign j_ext     = IDX_W'(j_r);
  assign addr_lo   = ((j_ext & ~low_mask) << 1) | (j_ext & low_mask);
  assign addr_hi   = addr_lo | agent_bit;

  always_comb begin
    pc = '0;
    for (int k = 0; k < JW; k++) begin
      pc = pc + NW'(j_r[k]);
    end
  end

  assign pop        = deq_valid && deq_ready;
  assign deq_ready  = (state_r == ST_IDLE);
  assign wr_idx     = IDX_W'(deq_data.coalition);
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign div_start  = (state_r == ST_DRAIN) && pipe_empty;
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign emit       = (state_r == ST_DIV) && div_done && out_free;
  assign last_agent = (a_r == n_eff - NW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_count_r <= CFG_RESET;
    end else if (cfg_we) begin
      agent_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wr_idx] <= deq_data.worth;
    end
    rd_hi_r <= mem[addr_hi];
    rd_lo_r <= mem[addr_lo];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbit_r <= '0;
      vh_r   <= 1'b0;
      vl_r   <= 1'b0;
    end else begin
      if (pop) begin
        vbit_r[wr_idx] <= 1'b1;
      end
      vh_r <= vbit_r[addr_hi];
      vl_r <= vbit_r[addr_lo];
    end
  end

  assign eff_hi  = vh_r ? rd_hi_r : '0;
  assign eff_lo  = vl_r ? rd_lo_r : '0;
  assign pc_rest = n_eff - NW'(1) - pc1_r;
  assign wt_full = 32'(fact_sel(FACT_SEL_W'(pc1_r))) * 32'(fact_sel(FACT_SEL_W'(pc_rest)));

  always_ff @(posedge clk) begin
    pc1_r   <= pc;
    diff2_r <= DIFF_W'(eff_hi) - DIFF_W'(eff_lo);
    wt2_r   <= wt_full[WW-1:0];
    prod3_r <= PW'($signed({1'b0, wt2_r})) * PW'(diff2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_r     <= '0;
      j_r     <= '0;
      acc_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_RUN);
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        acc_r <= acc_r + ACC_W'(prod3_r);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop && deq_data.last) begin
            a_r     <= '0;
            j_r     <= '0;
            acc_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (j_r == j_last) begin
            state_r <= ST_DRAIN;
          end else begin
            j_r <= j_r + JW'(1);
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (emit) begin
            if (last_agent) begin
              state_r <= ST_IDLE;
            end else begin
              a_r     <= a_r + NW'(1);
              j_r     <= '0;
              acc_r   <= '0;
              state_r <= ST_RUN;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  logic                   out_valid_r;
  logic [AGENT_W-1:0]     out_agent_r;
  logic signed [MT_W-1:0] out_mt_r;
  logic signed [Q_W-1:0]  out_q_r;
  logic                   out_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_agent_r <= AGENT_W'(a_r);
      out_mt_r    <= MT_W'(acc_r);
      out_q_r     <= Q_W'(div_q);
      out_final_r <= last_agent;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.agent          = out_agent_r;
  assign out_ch.marginal_total = out_mt_r;
  assign out_ch.shapley_q16    = out_q_r;
  assign out_ch.final_agent    = out_final_r;

  sve_div #(
    .ACC_W (ACC_W),
    .FW    (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (FW'(fact_sel(FACT_SEL_W'(n_eff)))),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

>>> rtl/sve_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sve_checker import sve_pkg::*; (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [AGENT_W+MT_W+Q_W:0]         out_payload
);

  `SVE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `SVE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_payload))
  `SVE_ASSERT_RST(a_rst_ready, !rst_n |=> in_ready)
  `SVE_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid)

endmodule

bind shapley_value_engine sve_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload ({out_ch.agent, out_ch.marginal_total, out_ch.shapley_q16,
                 out_ch.final_agent})
);

>>> bench/shapley_value_engine_test.sv
`timescale 1ns / 1ps

module shapley_value_engine_test import sve_pkg::*;;

  localparam int TABLE_DEPTH = 1 << DEF_MAX_AGENTS;
  localparam int QUIET_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 60;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS = 25;

  typedef struct {
    logic [AGENT_W-1:0] agent;
    logic [MT_W-1:0]    total;
    logic [Q_W-1:0]     value;
    logic               closing;
  } share_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  sve_in_if  in_ch ();
  sve_out_if out_ch ();

  shapley_value_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic signed [WORTH_W-1:0] worth_copy [TABLE_DEPTH];
  logic [CFG_W-1:0]          agent_count_copy;
  share_t                    pending_shares [$];
  int                        fail_count;
  int                        quiet_cycles;
  int                        idle_pct;
  int                        stall_pct;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint factorial(input int k);
    longint f;
    f = 1;
    for (int j = 2; j <= k; j++) f = f * j;
    return f;
  endfunction

  function automatic int active_agents(input logic [CFG_W-1:0] c);
    if (c < 2) return 2;
    if (c > DEF_MAX_AGENTS) return DEF_MAX_AGENTS;
    return int'(c);
  endfunction

  function automatic logic signed [WORTH_W-1:0] rand_worth();
    case ($urandom_range(3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return WORTH_W'($urandom);
    endcase
  endfunction

  task automatic predict_shares();
    int     n;
    int     s;
    int     bit_mask;
    longint fn;
    longint acc;
    longint q;
    share_t e;
    n = active_agents(agent_count_copy);
    fn = factorial(n);
    for (int i = 0; i < n; i++) begin
      bit_mask = 1 << i;
      acc = 0;
      for (int m = 0; m < (1 << n); m++) begin
        if ((m & bit_mask) == 0) begin
          s = $countones(m);
          acc = acc + factorial(s) * factorial(n - s - 1) *
                (longint'(worth_copy[m | bit_mask]) - longint'(worth_copy[m]));
        end
      end
      q = (acc * 65536) / fn;
      e.agent = AGENT_W'(i);
      e.total = MT_W'(acc);
      e.value = Q_W'(q);
      e.closing = (i == n - 1);
      pending_shares = {pending_shares, e};
    end
  endtask

  task automatic send_request(input logic [COAL_W-1:0] coal,
                              input logic signed [WORTH_W-1:0] w,
                              input logic done);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.coalition <= coal;
    in_ch.worth     <= w;
    in_ch.load_done <= done;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    worth_copy[coal] = w;
    if (done) predict_shares();
  endtask

  // hold the sender until every expected result is out, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_agent_count(input logic [CFG_W-1:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    agent_count_copy = c;
  endtask

  task automatic load_full_table(input int n);
    for (int k = 0; k < (1 << n); k++)
      send_request(COAL_W'(k), rand_worth(), k == (1 << n) - 1);
  endtask

  task automatic test_reset_state();
    send_request(6'd3, 16'sh7fff, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_request(6'd0, 16'sh8000, 1'b0);
    send_request(6'd1, 16'sh7fff, 1'b0);
    send_request(6'd2, 16'sh8000, 1'b0);
    send_request(6'd3, 16'sh7fff, 1'b1);
  endtask

  task automatic test_count_clamp();
    write_agent_count(3'd7);
    send_request(6'd63, 16'sh8000, 1'b1);
    write_agent_count(3'd0);
    send_request(6'd0, 16'sh7fff, 1'b1);
    write_agent_count(3'd1);
    send_request(6'd1, -16'sd1, 1'b1);
    write_agent_count(3'd3);
    load_full_table(3);
  endtask

  task automatic test_outer_bits();
    write_agent_count(3'd2);
    send_request(6'b101100, 16'sd12345, 1'b0);
    send_request(6'b111111, -16'sd5, 1'b0);
    send_request(6'd2, 16'sd100, 1'b1);
  endtask

  task automatic test_back_to_back_runs();
    send_request(6'd1, 16'sd7, 1'b1);
    send_request(6'd2, -16'sd7, 1'b1);
  endtask

  task automatic test_random_phases();
    int phase_items;
    int n;
    int cnt;
    int r;
    logic [CFG_W-1:0] c;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  c = 3'd2; end
        1: begin idle_pct = 71; stall_pct = 0;  c = 3'd6; end
        2: begin idle_pct = 0;  stall_pct = 71; c = 3'd3; end
        default: begin idle_pct = 13; stall_pct = 13; c = 3'd1; end
      endcase
      write_agent_count(c);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          r = $urandom_range(15);
          if (r == 0) c = $urandom_range(1) ? 3'd6 : 3'd7;
          else if (r <= 2) c = 3'd5;
          else if (r <= 5) c = 3'd4;
          else if (r <= 9) c = 3'd3;
          else c = CFG_W'($urandom_range(2));
          write_agent_count(c);
        end
        n = active_agents(agent_count_copy);
        r = $urandom_range(9);
        if (r <= 6) begin
          load_full_table(n);
          phase_items += 1 << n;
        end else if (r <= 8) begin
          cnt = $urandom_range(4, 1);
          for (int k = 0; k < cnt; k++)
            send_request(COAL_W'($urandom_range((1 << n) - 1)), rand_worth(), k == cnt - 1);
          phase_items += cnt;
        end else begin
          cnt = $urandom_range(4, 1);
          for (int k = 0; k < cnt; k++)
            send_request(COAL_W'($urandom), rand_worth(), 1'($urandom));
          phase_items += cnt;
        end
        if ($urandom_range(7) == 0) drain();
      end
    end
  endtask

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    share_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_shares.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected result: agent %0d total %0d q16 %0d final %0b",
                   out_ch.agent, out_ch.marginal_total, out_ch.shapley_q16,
                   out_ch.final_agent);
        fail_count++;
      end else begin
        e = pending_shares.pop_front();
        if (out_ch.agent !== e.agent || out_ch.marginal_total !== e.total ||
            out_ch.shapley_q16 !== e.value || out_ch.final_agent !== e.closing) begin
          if (fail_count < REPORT_LIMIT)
            $display("mismatch: agent %0d/%0d total %0d/%0d q16 %0d/%0d final %0b/%0b",
                     e.agent, out_ch.agent, $signed(e.total), out_ch.marginal_total,
                     $signed(e.value), out_ch.shapley_q16, e.closing, out_ch.final_agent);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("shapley_value_engine_test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.coalition = '0;
    in_ch.worth     = '0;
    in_ch.load_done = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    agent_count_copy = CFG_RESET;
    foreach (worth_copy[k]) worth_copy[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_field_extremes();
    test_count_clamp();
    test_outer_bits();
    test_back_to_back_runs();
    test_random_phases();
    drain();
    if (fail_count == 0 && pending_shares.size() == 0)
      $display("shapley_value_engine_test passed");
    else
      $display("shapley_value_engine_test failed");
    $finish;
  end

endmodule
